// File: src/pipc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_pkg: shared types for the point-in-convex-polygon tester
// Control and status bundles between the sequencer and the cross-product unit.
// ----------------------------------------------------------------------------
package pipc_pkg;

    // Step commands from the sequencer to the cross-product unit.
    typedef struct packed {
        logic start;   // capture the test point
        logic first;   // capture the first corner as the edge start
        logic load;    // form edge and point vectors, advance the edge start
        logic mul_a;   // first product: edge x times point vector y
        logic mul_b;   // second product: edge y times point vector x
    } pipc_ctrl_t;

    // Verdict of the current edge.
    typedef struct packed {
        logic skip;      // edge of zero length or point on the edge start
        logic positive;  // cross product strictly positive
    } pipc_stat_t;

endpackage

// File: src/pipc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_in_if: request channel of the polygon tester
// Carries a corner store or a point test with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pipc_in_if #(
    parameter int SLOT_W     = 4,
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [SLOT_W-1:0]            corner_slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (
        output valid, operation, corner_slot, coord_x, coord_y,
        input  ready
    );

    modport sink (
        input  valid, operation, corner_slot, coord_x, coord_y,
        output ready
    );
endinterface

// File: src/pipc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_out_if: result channel of the polygon tester
// Carries the inside flag of one point test with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pipc_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );

    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// File: src/pipc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_store: corner table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pipc_store #(
    parameter int DEPTH      = 16,
    parameter int ADDR_W     = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic signed [COORD_BITS-1:0] rd_x,
    output logic signed [COORD_BITS-1:0] rd_y
);

    logic [2*COORD_BITS-1:0] mem [DEPTH];
    logic [2*COORD_BITS-1:0] rd_data_reg;

    // Entries hold no reset value; the table is valid only once written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = $signed(rd_data_reg[2*COORD_BITS-1:COORD_BITS]);
    assign rd_y = $signed(rd_data_reg[COORD_BITS-1:0]);

endmodule

// File: src/pipc_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_cross: shared cross-product unit
// Forms edge and point vectors, then runs both products through one multiplier.
// ----------------------------------------------------------------------------
module pipc_cross
    import pipc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  pipc_ctrl_t                   ctrl,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    output pipc_stat_t                   stat
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [DIFF_W-1:0]     ex_reg, ey_reg, vx_reg, vy_reg;
    logic signed [DIFF_W-1:0]     ex_next, ey_next, vx_next, vy_next;
    logic                         skip_reg, skip_next;
    logic signed [DIFF_W-1:0]     op_a, op_b;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     prod_a_reg, prod_b_reg;

    // Differences are one bit wider than the coordinates, so they are exact.
    always_comb
    begin
        ex_next   = $signed({cur_x[COORD_BITS-1], cur_x})
                  - $signed({prev_x_reg[COORD_BITS-1], prev_x_reg});
        ey_next   = $signed({cur_y[COORD_BITS-1], cur_y})
                  - $signed({prev_y_reg[COORD_BITS-1], prev_y_reg});
        vx_next   = $signed({pt_x_reg[COORD_BITS-1], pt_x_reg})
                  - $signed({prev_x_reg[COORD_BITS-1], prev_x_reg});
        vy_next   = $signed({pt_y_reg[COORD_BITS-1], pt_y_reg})
                  - $signed({prev_y_reg[COORD_BITS-1], prev_y_reg});
        skip_next = ((ex_next == '0) && (ey_next == '0))
                 || ((vx_next == '0) && (vy_next == '0));
    end

    // The single multiplier takes its operands from the step being run.
    always_comb
    begin
        op_a = ctrl.mul_a ? ex_reg : ey_reg;
        op_b = ctrl.mul_a ? vy_reg : vx_reg;
        prod = op_a * op_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            pt_x_reg <= pt_x;
            pt_y_reg <= pt_y;
        end
        if (ctrl.first || ctrl.load)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (ctrl.load)
        begin
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            skip_reg <= skip_next;
        end
        if (ctrl.mul_a)
        begin
            prod_a_reg <= prod;
        end
        if (ctrl.mul_b)
        begin
            prod_b_reg <= prod;
        end
    end

    assign stat.skip     = skip_reg;
    assign stat.positive = (prod_a_reg > prod_b_reg);

endmodule

// File: src/point_in_convex_polygon_top.sv
`timescale 1ns / 1ps
// Sequence: a store to a slot inside the table is written on acceptance. A test
// transaction with n corners in use runs S_FIRST, then S_DIFF, S_MUL1, S_MUL2 and S_CMP
// for each edge, then S_DONE; an edge that rejects the point ends the walk early, and
// with no corners it goes straight to S_DONE, which waits for a free output register.
// One test runs at a time; the single shared multiplier forms both products in turn.
// Reset clears the corner count and the handshake state; the corner table is not cleared.
// ----------------------------------------------------------------------------
// point_in_convex_polygon_top: point-in-convex-polygon tester
// Keeps a table of polygon corners and tests points with a cross-product sign check.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_top
    import pipc_pkg::*;
#(
    parameter int MAX_CORNERS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pipc_in_if.sink                              req,
    pipc_out_if.source                           rsp,
    input  logic                                 cfg_wr_en,
    input  logic [$clog2(MAX_CORNERS + 1)-1:0]   cfg_wr_data
);

    localparam int ADDR_W = $clog2(MAX_CORNERS);
    localparam int CNT_W  = $clog2(MAX_CORNERS + 1);

    // Sequencer states. Each edge runs through DIFF, MUL1, MUL2 and CMP.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_DIFF  = 7'b0000100,
        S_MUL1  = 7'b0001000,
        S_MUL2  = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     corner_count_reg;
    logic [CNT_W-1:0]     count_clamp;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [ADDR_W-1:0]    edge_reg, edge_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 rsp_res_reg, rsp_res_next;

    logic                 accept;
    logic                 store_wr_en;
    logic [CNT_W-1:0]     addr_inc;
    logic [ADDR_W-1:0]    next_corner;
    logic                 last_edge;
    logic                 edge_fail;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;

    pipc_ctrl_t           ctrl;
    pipc_stat_t           stat;

    // ------------------------------------------------------------------------
    // Corner count register. A count above the table depth acts as the depth.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            corner_count_reg <= cfg_wr_data;
        end
    end

    assign count_clamp = (corner_count_reg > CNT_W'(MAX_CORNERS))
                       ? CNT_W'(MAX_CORNERS) : corner_count_reg;

    // ------------------------------------------------------------------------
    // Handshake. Requests are taken only when the sequencer is idle; a finished
    // result may still wait in the output register meanwhile.
    // ------------------------------------------------------------------------
    assign req.ready      = (state_reg == S_IDLE);
    assign accept         = req.valid && req.ready;
    assign store_wr_en    = accept && !req.operation
                         && (CNT_W'(req.corner_slot) < CNT_W'(MAX_CORNERS));
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.inside_res = rsp_res_reg;

    // Walking the corners: the edge end follows the edge start, wrapping at n.
    assign addr_inc    = CNT_W'(addr_reg) + CNT_W'(1);
    assign next_corner = (addr_inc == n_reg) ? '0 : addr_inc[ADDR_W-1:0];
    assign last_edge   = ((CNT_W'(edge_reg) + CNT_W'(1)) == n_reg);

    // An edge that cannot be judged never rejects the point; a cross product of
    // zero or less does.
    assign edge_fail   = !stat.skip && !stat.positive;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        edge_next      = edge_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_res_next   = rsp_res_reg;
        ctrl           = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.operation)
                begin
                    ctrl.start = 1'b1;
                    n_next     = count_clamp;
                    edge_next  = '0;
                    addr_next  = '0;
                    if (count_clamp == '0)
                    begin
                        // An empty polygon holds every point.
                        res_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                ctrl.first = 1'b1;
                addr_next  = next_corner;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                ctrl.load  = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                ctrl.mul_a = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctrl.mul_b = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (edge_fail || last_edge)
                begin
                    res_next   = !edge_fail;
                    state_next = S_DONE;
                end
                else
                begin
                    edge_next  = edge_reg + ADDR_W'(1);
                    addr_next  = next_corner;
                    state_next = S_DIFF;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        edge_reg    <= edge_next;
        addr_reg    <= addr_next;
        res_reg     <= res_next;
        rsp_res_reg <= rsp_res_next;
    end

    // ------------------------------------------------------------------------
    // Corner table. The read address is the next address, so the registered
    // read data always shows the corner at addr_reg.
    // ------------------------------------------------------------------------
    pipc_store #(
        .DEPTH      (MAX_CORNERS),
        .ADDR_W     (ADDR_W),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (req.corner_slot),
        .wr_x    (req.coord_x),
        .wr_y    (req.coord_y),
        .rd_addr (addr_next),
        .rd_x    (cur_x),
        .rd_y    (cur_y)
    );

    // ------------------------------------------------------------------------
    // Shared cross-product unit.
    // ------------------------------------------------------------------------
    pipc_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk   (clk),
        .ctrl  (ctrl),
        .pt_x  (req.coord_x),
        .pt_y  (req.coord_y),
        .cur_x (cur_x),
        .cur_y (cur_y),
        .stat  (stat)
    );

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // A store transaction never produces a result.
    a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.operation) |=> !$rose(rsp_valid_reg))
        else $error("result raised after a store transaction");

    // A test transaction makes the block busy in the next cycle.
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.operation) |=> !req.ready)
        else $error("block still ready after accepting a test transaction");

    // The edge counter stays below the corner count while edges are judged.
    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (CNT_W'(edge_reg) < n_reg))
        else $error("edge counter beyond the corner count");

endmodule
